>>> hw/rtl/dbd_pkg.sv
// ----------------------------------------------------------------------------
// dbd_pkg
// shared types, constants and calendar tables for days_between_dates
// ----------------------------------------------------------------------------
package dbd_pkg;

  localparam int MAX_YEAR  = 9999;
  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 14;
  localparam int ORD_W     = 23;
  localparam int COUNT_W   = 22;
  localparam int LEAPS_W   = 12;
  localparam int DOY_W     = 9;
  localparam int IN_W      = 48;
  localparam int OUT_W     = 24;

  // y / 100 as (y * RECIP_100) >> RECIP_SHIFT, exact for 14-bit years
  localparam int RECIP_W     = 13;
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = YEAR_W + RECIP_W;
  localparam int Q100_W      = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] SPAN_MAX   = 22'd3652424;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_DATE  = 2'd1,
    ERR_ORDER = 2'd2
  } dbd_err_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } dbd_ctrl_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] n;
    unique case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

>>> hw/rtl/dbd_date_conv.sv
// ----------------------------------------------------------------------------
// dbd_date_conv
// three-stage date to ordinal day converter with validity check
// ----------------------------------------------------------------------------
module dbd_date_conv (
  input  logic                            clk,
  input  dbd_pkg::dbd_ctrl_t              ctrl,
  input  logic [dbd_pkg::DAY_W-1:0]       day,
  input  logic [dbd_pkg::MONTH_W-1:0]     month,
  input  logic [dbd_pkg::YEAR_W-1:0]      year,
  output logic [dbd_pkg::ORD_W-1:0]       ord,
  output logic                            ok
);

  // stage 1
  logic [dbd_pkg::DAY_W-1:0]   d1;
  logic [dbd_pkg::MONTH_W-1:0] m1;
  logic [dbd_pkg::YEAR_W-1:0]  y1;
  logic [dbd_pkg::PROD_W-1:0]  prod1;
  logic                        ok1;

  // stage 2
  logic [dbd_pkg::YEAR_W-1:0]  y2;
  logic [dbd_pkg::LEAPS_W-1:0] leaps2;
  logic [dbd_pkg::DOY_W-1:0]   doy2;
  logic                        ok2;

  // stage 2 logic
  logic [dbd_pkg::Q100_W-1:0]  q100;
  logic [dbd_pkg::YEAR_W-1:0]  hund;
  logic [dbd_pkg::YEAR_W-1:0]  r100_w;
  logic                        y4z;
  logic                        r0;
  logic                        q4z;
  logic                        leap;
  logic [dbd_pkg::LEAPS_W:0]   leaps_w;
  logic [dbd_pkg::DAY_W:0]     len;
  logic [dbd_pkg::DOY_W-1:0]   doy_w;

  always_comb begin
    q100    = prod1[dbd_pkg::RECIP_SHIFT +: dbd_pkg::Q100_W];
    hund    = dbd_pkg::YEAR_W'(q100) * dbd_pkg::YEAR_W'(100);
    r100_w  = y1 - hund;
    y4z     = (y1[1:0] == 2'd0);
    r0      = (r100_w == '0);
    q4z     = (q100[1:0] == 2'd0);
    leap    = (y4z && !r0) || (r0 && q4z);
    // leap years in 0 .. y-1 as ceil(y/4) - ceil(y/100) + ceil(y/400)
    leaps_w = (dbd_pkg::LEAPS_W+1)'(y1 >> 2) + (dbd_pkg::LEAPS_W+1)'(!y4z)
            - (dbd_pkg::LEAPS_W+1)'(q100) - (dbd_pkg::LEAPS_W+1)'(!r0)
            + (dbd_pkg::LEAPS_W+1)'(q100 >> 2) + (dbd_pkg::LEAPS_W+1)'(!(r0 && q4z));
    len     = {1'b0, dbd_pkg::month_len(m1)} + (dbd_pkg::DAY_W+1)'(m1 == 4'd2 && leap);
    doy_w   = dbd_pkg::days_before(m1) + dbd_pkg::DOY_W'(m1 > 4'd2 && leap)
            + dbd_pkg::DOY_W'(d1) - dbd_pkg::DOY_W'(1);
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      d1    <= day;
      m1    <= month;
      y1    <= year;
      prod1 <= dbd_pkg::PROD_W'(year) * dbd_pkg::PROD_W'(dbd_pkg::RECIP_100);
      ok1   <= (month >= 4'd1) && (month <= 4'd12) && (day != '0)
               && (32'(year) <= dbd_pkg::MAX_YEAR);
    end
    if (ctrl.ld2) begin
      y2     <= y1;
      leaps2 <= leaps_w[dbd_pkg::LEAPS_W-1:0];
      doy2   <= doy_w;
      ok2    <= ok1 && ({1'b0, d1} <= len);
    end
    if (ctrl.ld3) begin
      ord <= dbd_pkg::ORD_W'(y2) * dbd_pkg::ORD_W'(365)
           + dbd_pkg::ORD_W'(leaps2) + dbd_pkg::ORD_W'(doy2);
      ok  <= ok2;
    end
  end

endmodule

>>> hw/rtl/dbd_diff.sv
// ----------------------------------------------------------------------------
// dbd_diff
// final stage: ordering check, difference, saturation and error code
// ----------------------------------------------------------------------------
module dbd_diff (
  input  logic                          clk,
  input  dbd_pkg::dbd_ctrl_t            ctrl,
  input  logic [dbd_pkg::ORD_W-1:0]     ord_a,
  input  logic                          ok_a,
  input  logic [dbd_pkg::ORD_W-1:0]     ord_b,
  input  logic                          ok_b,
  output logic [dbd_pkg::COUNT_W-1:0]   day_count,
  output dbd_pkg::dbd_err_t             date_error
);

  logic [dbd_pkg::ORD_W-1:0] diff;

  assign diff = ord_b - ord_a;

  always_ff @(posedge clk) begin
    if (ctrl.ld4) begin
      priority if (!ok_a || !ok_b) begin
        day_count  <= '0;
        date_error <= dbd_pkg::ERR_DATE;
      end else if (ord_b < ord_a) begin
        day_count  <= '0;
        date_error <= dbd_pkg::ERR_ORDER;
      end else if (diff > dbd_pkg::ORD_W'(dbd_pkg::COUNT_MAX)) begin
        day_count  <= dbd_pkg::COUNT_MAX;
        date_error <= dbd_pkg::ERR_NONE;
      end else begin
        day_count  <= diff[dbd_pkg::COUNT_W-1:0];
        date_error <= dbd_pkg::ERR_NONE;
      end
    end
  end

endmodule

>>> hw/rtl/days_between_dates.sv
// ----------------------------------------------------------------------------
// days_between_dates
// day count between two gregorian dates over a four-stage pipeline
// ----------------------------------------------------------------------------
// Each input beat carries a start and an end date; each output beat gives the
// days from start to end with an error code in tuser (0 ok, 1 bad month, day
// or year, 2 end before start, count zero on error). One beat can enter every
// cycle while the output is not stalled; the stages are the reciprocal multiply
// for the divide by 100, the leap and month tables, the year times 365
// multiply, and the compare and subtract. Each stage holds its beat while the
// one after it is full and held, so bubbles close up under output stalls.
module days_between_dates (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // start_day, start_month, start_year, end_day, end_month, end_year, zero pad
  input  logic [dbd_pkg::IN_W-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // day_count, zero pad
  output logic [dbd_pkg::OUT_W-1:0]    m_tdata,
  // date_error
  output logic [1:0]                   m_tuser
);

  logic [3:0]                    v;
  dbd_pkg::dbd_ctrl_t            ctrl;
  logic [dbd_pkg::ORD_W-1:0]     ord_a;
  logic [dbd_pkg::ORD_W-1:0]     ord_b;
  logic                          ok_a;
  logic                          ok_b;
  logic [dbd_pkg::COUNT_W-1:0]   day_count;
  dbd_pkg::dbd_err_t             date_error;

  always_comb begin
    ctrl.ld4 = !v[3] || m_tready;
    ctrl.ld3 = !v[2] || ctrl.ld4;
    ctrl.ld2 = !v[1] || ctrl.ld3;
    ctrl.ld1 = !v[0] || ctrl.ld2;
  end

  assign s_tready = ctrl.ld1;
  assign m_tvalid = v[3];
  assign m_tdata  = dbd_pkg::OUT_W'(day_count);
  assign m_tuser  = date_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ctrl.ld1) v[0] <= s_tvalid;
      if (ctrl.ld2) v[1] <= v[0];
      if (ctrl.ld3) v[2] <= v[1];
      if (ctrl.ld4) v[3] <= v[2];
    end
  end

  dbd_date_conv u_conv_start (
    .clk   (clk),
    .ctrl  (ctrl),
    .day   (s_tdata[4:0]),
    .month (s_tdata[8:5]),
    .year  (s_tdata[22:9]),
    .ord   (ord_a),
    .ok    (ok_a)
  );

  dbd_date_conv u_conv_end (
    .clk   (clk),
    .ctrl  (ctrl),
    .day   (s_tdata[27:23]),
    .month (s_tdata[31:28]),
    .year  (s_tdata[45:32]),
    .ord   (ord_b),
    .ok    (ok_b)
  );

  dbd_diff u_diff (
    .clk        (clk),
    .ctrl       (ctrl),
    .ord_a      (ord_a),
    .ok_a       (ok_a),
    .ord_b      (ord_b),
    .ok_b       (ok_b),
    .day_count  (day_count),
    .date_error (date_error)
  );

endmodule

>>> hw/rtl/dbd_checker.sv
// ----------------------------------------------------------------------------
// dbd_checker
// port-level checks for days_between_dates, bound to the top level
// ----------------------------------------------------------------------------
module dbd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [dbd_pkg::OUT_W-1:0]  m_tdata,
  input logic [1:0]                 m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat dropped while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != dbd_pkg::ERR_NONE) |-> (m_tdata == '0))
    else $error("nonzero count on error beat");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == dbd_pkg::ERR_NONE) || (m_tuser == dbd_pkg::ERR_DATE)
                 || (m_tuser == dbd_pkg::ERR_ORDER))
    else $error("undefined error code");

  a_span: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == dbd_pkg::ERR_NONE)
      |-> (m_tdata[dbd_pkg::COUNT_W-1:0] <= dbd_pkg::SPAN_MAX))
    else $error("count beyond calendar span");

endmodule

bind days_between_dates dbd_checker u_dbd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> test/days_between_dates_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// days_between_dates_test
// self-checking bench for the gregorian day count between two dates
// ----------------------------------------------------------------------------
// A directed table covers the calendar edges, every error code and the widest
// span. A long random run follows, mostly well-formed date pairs with some
// swapped pairs and raw noise. Each output beat is compared with a calendar
// predictor held inside the bench. Both handshake sides idle at random,
// except for one stretch of back-to-back traffic.
module days_between_dates_test;

  localparam int CLK_HALF    = 4;
  localparam int RST_CYCLES  = 12;
  localparam int RAND_ITEMS  = 1400;
  localparam int QUIET_FIRST = 700;
  localparam int QUIET_LAST  = 999;
  localparam int DRAIN_WAIT  = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS    = 21;

  typedef struct {
    logic [dbd_pkg::COUNT_W-1:0] count;
    dbd_pkg::dbd_err_t           err;
  } span_t;

  typedef struct {
    int                sd;
    int                sm;
    int                sy;
    int                ed;
    int                em;
    int                ey;
    bit                typed;
    int                count;
    dbd_pkg::dbd_err_t err;
  } row_t;

  logic                       clk      = 1'b0;
  logic                       rst      = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [dbd_pkg::IN_W-1:0]   s_tdata  = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [dbd_pkg::OUT_W-1:0]  m_tdata;
  logic [1:0]                 m_tuser;

  span_t pending_spans [$];
  span_t oldest_span;
  row_t  dir_rows [DIR_ROWS];
  bit    quiet       = 1'b0;
  int    fail_count  = 0;
  int    cycle_count = 0;

  days_between_dates i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(input int m, input int y);
    int n;
    case (m)
      1, 3, 5, 7, 8, 10, 12: n = 31;
      4, 6, 9, 11:           n = 30;
      2:                     n = leap_year(y) ? 29 : 28;
      default:               n = 0;
    endcase
    return n;
  endfunction

  // day number counted from 1 january of year 0
  function automatic bit date_ordinal(input int d, input int m, input int y, output int ord);
    int leaps;
    int prior_days;
    ord = 0;
    if (m < 1 || m > 12 || y > dbd_pkg::MAX_YEAR || d < 1 || d > month_days(m, y))
      return 1'b0;
    prior_days = 0;
    for (int k = 1; k < m; k++)
      prior_days += month_days(k, y);
    leaps = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    ord = 365 * y + leaps + prior_days + d - 1;
    return 1'b1;
  endfunction

  function automatic span_t date_span(input int sd, input int sm, input int sy,
                                      input int ed, input int em, input int ey);
    span_t r;
    int    a;
    int    b;
    bit    ok_a;
    bit    ok_b;
    ok_a = date_ordinal(sd, sm, sy, a);
    ok_b = date_ordinal(ed, em, ey, b);
    r.count = '0;
    if (!ok_a || !ok_b)
      r.err = dbd_pkg::ERR_DATE;
    else if (b < a)
      r.err = dbd_pkg::ERR_ORDER;
    else begin
      r.err   = dbd_pkg::ERR_NONE;
      r.count = (b - a > int'(dbd_pkg::COUNT_MAX)) ? dbd_pkg::COUNT_MAX
                                                    : dbd_pkg::COUNT_W'(b - a);
    end
    return r;
  endfunction

  task automatic random_date(output int d, output int m, output int y);
    int pick;
    pick = $urandom_range(99);
    if (pick < 10)
      y = $urandom_range(3);
    else if (pick < 20)
      y = $urandom_range(dbd_pkg::MAX_YEAR, dbd_pkg::MAX_YEAR - 3);
    else if (pick < 30)
      y = 100 * $urandom_range(dbd_pkg::MAX_YEAR / 100);
    else
      y = $urandom_range(dbd_pkg::MAX_YEAR);
    m = $urandom_range(12, 1);
    d = $urandom_range(month_days(m, y), 1);
  endtask

  task automatic send_dates(input int sd, input int sm, input int sy,
                            input int ed, input int em, input int ey);
    if (!quiet && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, dbd_pkg::YEAR_W'(ey), dbd_pkg::MONTH_W'(em), dbd_pkg::DAY_W'(ed),
                 dbd_pkg::YEAR_W'(sy), dbd_pkg::MONTH_W'(sm), dbd_pkg::DAY_W'(sd)};
    do @(posedge clk); while (!s_tready);
    pending_spans.push_back(date_span(sd, sm, sy, ed, em, ey));
  endtask

  initial begin
    int    sd, sm, sy, ed, em, ey;
    int    oa, ob, t, mode;
    span_t want;
    dir_rows = '{
      '{1, 1, 0,  1, 1, 0,  1, 0, dbd_pkg::ERR_NONE},
      '{1, 1, 0,  31, 12, dbd_pkg::MAX_YEAR,  1, 3652424, dbd_pkg::ERR_NONE},
      '{1, 1, 0,  1, 1, 1,  1, 366, dbd_pkg::ERR_NONE},
      '{31, 12, dbd_pkg::MAX_YEAR,  31, 12, dbd_pkg::MAX_YEAR,  1, 0, dbd_pkg::ERR_NONE},
      '{28, 2, 1900,  1, 3, 1900,  0, 0, dbd_pkg::ERR_NONE},
      '{28, 2, 2000,  1, 3, 2000,  0, 0, dbd_pkg::ERR_NONE},
      '{29, 2, 2000,  29, 2, 2400,  0, 0, dbd_pkg::ERR_NONE},
      '{31, 1, 2023,  1, 2, 2023,  0, 0, dbd_pkg::ERR_NONE},
      '{15, 6, 1999,  15, 6, 2025,  0, 0, dbd_pkg::ERR_NONE},
      '{31, 12, 2099,  1, 1, 2100,  0, 0, dbd_pkg::ERR_NONE},
      '{29, 2, 1900,  1, 3, 1900,  1, 0, dbd_pkg::ERR_DATE},
      '{0, 5, 2020,  1, 6, 2020,  1, 0, dbd_pkg::ERR_DATE},
      '{1, 0, 2020,  1, 1, 2021,  1, 0, dbd_pkg::ERR_DATE},
      '{1, 1, 2020,  1, 13, 2021,  1, 0, dbd_pkg::ERR_DATE},
      '{31, 15, 16383,  31, 15, 16383,  1, 0, dbd_pkg::ERR_DATE},
      '{1, 1, dbd_pkg::MAX_YEAR+1,  1, 1, dbd_pkg::MAX_YEAR+1,  1, 0, dbd_pkg::ERR_DATE},
      '{1, 1, 2020,  1, 1, 16383,  1, 0, dbd_pkg::ERR_DATE},
      '{31, 4, 2021,  1, 5, 2021,  1, 0, dbd_pkg::ERR_DATE},
      '{30, 2, 2000,  1, 1, 1999,  1, 0, dbd_pkg::ERR_DATE},
      '{2, 1, 2020,  1, 1, 2020,  1, 0, dbd_pkg::ERR_ORDER},
      '{31, 12, dbd_pkg::MAX_YEAR,  1, 1, 0,  1, 0, dbd_pkg::ERR_ORDER}
    };

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        want.count = dbd_pkg::COUNT_W'(dir_rows[i].count);
        want.err   = dir_rows[i].err;
      end
      send_dates(dir_rows[i].sd, dir_rows[i].sm, dir_rows[i].sy,
                 dir_rows[i].ed, dir_rows[i].em, dir_rows[i].ey);
      if (dir_rows[i].typed)
        pending_spans[pending_spans.size() - 1] = want;
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      quiet = (n >= QUIET_FIRST && n <= QUIET_LAST);
      mode  = $urandom_range(99);
      random_date(sd, sm, sy);
      random_date(ed, em, ey);
      if (mode < 15) begin
        ey = (sy < dbd_pkg::MAX_YEAR) ? sy + $urandom_range(1) : sy;
        em = $urandom_range(12, 1);
        ed = $urandom_range(month_days(em, ey), 1);
      end else if (mode < 20) begin
        ed = sd;
        em = sm;
        ey = sy;
      end
      if (mode < 70) begin
        // order the pair so the end date does not come first
        void'(date_ordinal(sd, sm, sy, oa));
        void'(date_ordinal(ed, em, ey, ob));
        if (ob < oa) begin
          t = sd; sd = ed; ed = t;
          t = sm; sm = em; em = t;
          t = sy; sy = ey; ey = t;
        end
      end else if (mode >= 85) begin
        sd = $urandom_range(31);
        sm = $urandom_range(15);
        sy = $urandom_range(16383);
        if (mode >= 92) begin
          ed = $urandom_range(31);
          em = $urandom_range(15);
          ey = $urandom_range(16383);
        end
      end
      send_dates(sd, sm, sy, ed, em, ey);
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;

    while (pending_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending_spans.size() == 0)
      $display("PASS days_between_dates");
    else
      $display("FAIL days_between_dates");
    $finish;
  end

  always @(posedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= quiet || ($urandom_range(99) >= 17);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_spans.size() == 0) begin
        $display("%0t unexpected beat day_count %0d date_error %0d",
                 $time, m_tdata, m_tuser);
        fail_count++;
      end else begin
        oldest_span = pending_spans.pop_front();
        if (m_tdata !== {{(dbd_pkg::OUT_W-dbd_pkg::COUNT_W){1'b0}}, oldest_span.count}) begin
          $display("%0t day_count mismatch expected %0d actual %0d",
                   $time, oldest_span.count, m_tdata);
          fail_count++;
        end
        if (m_tuser !== oldest_span.err) begin
          $display("%0t date_error mismatch expected %0d actual %0d",
                   $time, oldest_span.err, m_tuser);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d beats outstanding", $time, pending_spans.size());
      $display("FAIL days_between_dates");
      $finish;
    end
  end

endmodule
